>>> hw/rtl/isq_pkg.sv
// Shared types and constants for the indexed sequence store.
// Holds the store depth, derived widths, command and status codes,
// the sequencer state type and the structs passed between modules.
package isq_pkg;

  // Store depth and the widths that follow from it.
  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // Compare width that holds both the count and the 5-bit position field.
  localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam int DATA_W = 32;

  // Command codes.
  localparam logic [2:0] CMD_PUSH_HEAD = 3'd0;
  localparam logic [2:0] CMD_PUSH_TAIL = 3'd1;
  localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
  localparam logic [2:0] CMD_POP_TAIL  = 3'd3;
  localparam logic [2:0] CMD_INSERT    = 3'd4;
  localparam logic [2:0] CMD_EXTRACT   = 3'd5;
  localparam logic [2:0] CMD_SWAP      = 3'd6;

  // Status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;
  localparam logic [1:0] STATUS_FULL  = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPEN_RD,
    ST_OPEN_WR,
    ST_PUT,
    ST_TAKE_RD,
    ST_TAKE_CAP,
    ST_CLOSE_RD,
    ST_CLOSE_WR,
    ST_SWAP_RDA,
    ST_SWAP_RDB,
    ST_SWAP_WRA,
    ST_SWAP_WRB,
    ST_DONE
  } isq_state_e;

  // Access request from the sequencer to the element memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } isq_mem_req_t;

  // One finished result item.
  typedef struct packed {
    logic [DATA_W-1:0] taken;
    logic [4:0]        occupancy;
    logic [1:0]        status;
  } isq_result_t;

endpackage

>>> hw/rtl/isq_ram.sv
// Element memory of the indexed sequence store: one write and one read port.
// Read data is registered. Depends on isq_pkg for depth and widths.
module isq_ram (
  input  logic                         clk_i,
  input  isq_pkg::isq_mem_req_t        req_i,
  output logic [isq_pkg::DATA_W-1:0]   rdata_o
);

  logic [isq_pkg::DATA_W-1:0] mem_q [isq_pkg::DEPTH];
  logic [isq_pkg::DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/isq_ctrl.sv
// Command sequencer of the indexed sequence store. It checks each item,
// then moves elements one at a time through the memory port. Uses isq_pkg.
module isq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  cmd_i,
  input  logic [31:0]                 value_i,
  input  logic [4:0]                  position_a_i,
  input  logic [3:0]                  position_b_i,
  input  logic                        out_free_i,
  output logic                        done_o,
  output isq_pkg::isq_result_t        result_o,
  output isq_pkg::isq_mem_req_t       mem_req_o,
  input  logic [isq_pkg::DATA_W-1:0]  rdata_i
);

  isq_pkg::isq_state_e                state_q, state_d;
  logic [isq_pkg::CNT_W-1:0]          count_q, count_d;
  logic [isq_pkg::ADDR_W-1:0]         idx_q, idx_d;
  logic [isq_pkg::ADDR_W-1:0]         at_q, at_d;
  logic [isq_pkg::ADDR_W-1:0]         pb_q, pb_d;
  logic [isq_pkg::DATA_W-1:0]         val_q, val_d;
  logic [isq_pkg::DATA_W-1:0]         taken_q, taken_d;
  logic [isq_pkg::DATA_W-1:0]         swap_q, swap_d;
  logic [1:0]                         status_q, status_d;

  logic [isq_pkg::CMP_W-1:0]          pa_ext, pb_ext, cnt_ext;
  logic                               full, empty;
  logic [isq_pkg::ADDR_W-1:0]         idx_dec, idx_inc;
  logic [isq_pkg::CNT_W-1:0]          idx_inc_cnt;

  // Range checks on the incoming item against the current count.
  assign pa_ext  = isq_pkg::CMP_W'(position_a_i);
  assign pb_ext  = isq_pkg::CMP_W'(position_b_i);
  assign cnt_ext = isq_pkg::CMP_W'(count_q);
  assign full    = (count_q == isq_pkg::CNT_W'(isq_pkg::DEPTH));
  assign empty   = (count_q == '0);

  // The shared index step unit.
  assign idx_dec     = idx_q - 1'b1;
  assign idx_inc     = idx_q + 1'b1;
  assign idx_inc_cnt = isq_pkg::CNT_W'(idx_q) + isq_pkg::CNT_W'(1);

  // Next state and working registers.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    at_d     = at_q;
    pb_d     = pb_q;
    val_d    = val_q;
    taken_d  = taken_q;
    swap_d   = swap_q;
    status_d = status_q;
    unique case (state_q)
      isq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          status_d = isq_pkg::STATUS_OK;
          taken_d  = '0;
          val_d    = value_i;
          pb_d     = isq_pkg::ADDR_W'(position_b_i);
          state_d  = isq_pkg::ST_DONE;
          unique case (cmd_i)
            isq_pkg::CMD_PUSH_HEAD, isq_pkg::CMD_PUSH_TAIL: begin
              if (full) begin
                status_d = isq_pkg::STATUS_FULL;
              end else begin
                count_d = count_q + 1'b1;
                idx_d   = isq_pkg::ADDR_W'(count_q);
                if (cmd_i == isq_pkg::CMD_PUSH_HEAD) begin
                  at_d    = '0;
                  state_d = empty ? isq_pkg::ST_PUT : isq_pkg::ST_OPEN_RD;
                end else begin
                  at_d    = isq_pkg::ADDR_W'(count_q);
                  state_d = isq_pkg::ST_PUT;
                end
              end
            end
            isq_pkg::CMD_INSERT: begin
              if (pa_ext > cnt_ext) begin
                status_d = isq_pkg::STATUS_RANGE;
              end else if (full) begin
                status_d = isq_pkg::STATUS_FULL;
              end else begin
                count_d = count_q + 1'b1;
                idx_d   = isq_pkg::ADDR_W'(count_q);
                at_d    = isq_pkg::ADDR_W'(position_a_i);
                state_d = (pa_ext == cnt_ext) ? isq_pkg::ST_PUT : isq_pkg::ST_OPEN_RD;
              end
            end
            isq_pkg::CMD_POP_HEAD, isq_pkg::CMD_POP_TAIL: begin
              if (empty) begin
                status_d = isq_pkg::STATUS_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
                at_d    = (cmd_i == isq_pkg::CMD_POP_HEAD) ? '0 :
                          isq_pkg::ADDR_W'(count_q - 1'b1);
                state_d = isq_pkg::ST_TAKE_RD;
              end
            end
            isq_pkg::CMD_EXTRACT: begin
              if (empty) begin
                status_d = isq_pkg::STATUS_EMPTY;
              end else if (pa_ext >= cnt_ext) begin
                status_d = isq_pkg::STATUS_RANGE;
              end else begin
                count_d = count_q - 1'b1;
                at_d    = isq_pkg::ADDR_W'(position_a_i);
                state_d = isq_pkg::ST_TAKE_RD;
              end
            end
            isq_pkg::CMD_SWAP: begin
              if (pa_ext >= cnt_ext || pb_ext >= cnt_ext) begin
                status_d = isq_pkg::STATUS_RANGE;
              end else begin
                at_d    = isq_pkg::ADDR_W'(position_a_i);
                state_d = isq_pkg::ST_SWAP_RDA;
              end
            end
            default: begin
              // The unused command reports success and changes nothing.
              state_d = isq_pkg::ST_DONE;
            end
          endcase
        end
      end
      isq_pkg::ST_OPEN_RD: begin
        state_d = isq_pkg::ST_OPEN_WR;
      end
      isq_pkg::ST_OPEN_WR: begin
        idx_d   = idx_dec;
        state_d = (idx_dec == at_q) ? isq_pkg::ST_PUT : isq_pkg::ST_OPEN_RD;
      end
      isq_pkg::ST_PUT: begin
        state_d = isq_pkg::ST_DONE;
      end
      isq_pkg::ST_TAKE_RD: begin
        state_d = isq_pkg::ST_TAKE_CAP;
      end
      isq_pkg::ST_TAKE_CAP: begin
        // The count already holds the new value, so the tail shift runs
        // while the index stays below it.
        taken_d = rdata_i;
        idx_d   = at_q;
        state_d = (isq_pkg::CNT_W'(at_q) < count_q) ? isq_pkg::ST_CLOSE_RD :
                  isq_pkg::ST_DONE;
      end
      isq_pkg::ST_CLOSE_RD: begin
        state_d = isq_pkg::ST_CLOSE_WR;
      end
      isq_pkg::ST_CLOSE_WR: begin
        idx_d   = idx_inc;
        state_d = (idx_inc_cnt < count_q) ? isq_pkg::ST_CLOSE_RD : isq_pkg::ST_DONE;
      end
      isq_pkg::ST_SWAP_RDA: begin
        state_d = isq_pkg::ST_SWAP_RDB;
      end
      isq_pkg::ST_SWAP_RDB: begin
        swap_d  = rdata_i;
        state_d = isq_pkg::ST_SWAP_WRA;
      end
      isq_pkg::ST_SWAP_WRA: begin
        state_d = isq_pkg::ST_SWAP_WRB;
      end
      isq_pkg::ST_SWAP_WRB: begin
        state_d = isq_pkg::ST_DONE;
      end
      isq_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = isq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = isq_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory requests and handshake outputs for each state.
  always_comb begin
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = idx_q;
    mem_req_o.wdata = rdata_i;
    mem_req_o.raddr = idx_q;
    done_o          = 1'b0;
    in_stall_o      = (state_q != isq_pkg::ST_IDLE);
    unique case (state_q)
      isq_pkg::ST_OPEN_RD: begin
        mem_req_o.raddr = idx_dec;
      end
      isq_pkg::ST_OPEN_WR, isq_pkg::ST_CLOSE_WR: begin
        mem_req_o.we = 1'b1;
      end
      isq_pkg::ST_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = at_q;
        mem_req_o.wdata = val_q;
      end
      isq_pkg::ST_TAKE_RD, isq_pkg::ST_SWAP_RDA: begin
        mem_req_o.raddr = at_q;
      end
      isq_pkg::ST_CLOSE_RD: begin
        mem_req_o.raddr = idx_inc;
      end
      isq_pkg::ST_SWAP_RDB: begin
        mem_req_o.raddr = pb_q;
      end
      isq_pkg::ST_SWAP_WRA: begin
        // The read of the second position lands here.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = at_q;
      end
      isq_pkg::ST_SWAP_WRB: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pb_q;
        mem_req_o.wdata = swap_q;
      end
      isq_pkg::ST_DONE: begin
        done_o = out_free_i;
      end
      default: begin
      end
    endcase
  end

  assign result_o.taken     = taken_q;
  assign result_o.occupancy = 5'(count_q);
  assign result_o.status    = status_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isq_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    at_q     <= at_d;
    pb_q     <= pb_d;
    val_q    <= val_d;
    taken_q  <= taken_d;
    swap_q   <= swap_d;
    status_q <= status_d;
  end

endmodule

>>> hw/rtl/indexed_sequence_store.sv
// Each item: a failed or unused command goes straight to the done state; a tail push or an
// insert at the tail writes the element in the put state; other pushes and inserts first
// move each element up one place by a read and a write; pops and extracts read and capture
// the element, then move the later elements down; a swap reads both positions, then writes
// both. Items are taken one at a time, and a result waits while the output still holds one.
// Reset clears the count, the sequencer and the output valid flag, not the element memory.
module indexed_sequence_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] value_i,
  input  logic [4:0]         position_a_i,
  input  logic [3:0]         position_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] taken_value_o,
  output logic [4:0]         occupancy_o,
  output logic [1:0]         status_o
);

  isq_pkg::isq_mem_req_t       mem_req;
  logic [isq_pkg::DATA_W-1:0]  rdata;
  isq_pkg::isq_result_t        result;
  isq_pkg::isq_result_t        out_q;
  logic                        out_valid_q, out_valid_d;
  logic                        out_free;
  logic                        done;

  // The output register is free when empty or when its item leaves now.
  assign out_free = !out_valid_q || !out_stall_i;

  isq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .position_a_i (position_a_i),
    .position_b_i (position_b_i),
    .out_free_i   (out_free),
    .done_o       (done),
    .result_o     (result),
    .mem_req_o    (mem_req),
    .rdata_i      (rdata)
  );

  isq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Output valid flag.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign taken_value_o = out_q.taken;
  assign occupancy_o   = out_q.occupancy;
  assign status_o      = out_q.status;

endmodule
